>>> design/circular_region_occupancy_monitor_assert.svh
// assertion macros for the circular region occupancy monitor
`ifndef CIRCULAR_REGION_OCCUPANCY_MONITOR_ASSERT_SVH
`define CIRCULAR_REGION_OCCUPANCY_MONITOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define CROM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crom assertion failed");
`define CROM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crom assertion failed");
`else
`define CROM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CROM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/crom_pkg.sv
// shared types, constants and helpers of the circular region occupancy monitor
package crom_pkg;

  localparam int MAX_GRID_SIDE = 1024;
  localparam int CNT_W   = $clog2(MAX_GRID_SIDE);
  localparam int SIDE_W  = CNT_W + 1;
  localparam int COORD_W = SIDE_W + 1;
  localparam int SQ_W    = 2 * SIDE_W;

  localparam int GEOM_W   = 11;
  localparam int RADIUS_W = 21;
  localparam int OCC_TH_W = 7;
  localparam int COV_W    = 16;
  localparam int MASK_W   = 16;
  localparam int CFG_W    = 21;
  localparam int CFG_IDX_W = 3;

  localparam int DIST_W = (SQ_W + 1 > RADIUS_W) ? SQ_W + 1 : RADIUS_W;
  localparam int COUNT_W = 21;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int PROD_W = COUNT_W + COV_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [1:0] CMD_CELL = 2'd0;
  localparam logic [1:0] CMD_DOCK = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_TH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COV_TH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MASK  = 3'd5;

  localparam logic [7:0] DOCK_STATE_INVALID = 8'd255;

  typedef enum logic [1:0] {
    KIND_CELL,
    KIND_DOCK,
    KIND_TICK
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic signed [7:0]  cell_value;
    logic [7:0]         dock_state;
  } q_item_t;

  typedef struct packed {
    logic [GEOM_W-1:0]   grid_width;
    logic [GEOM_W-1:0]   grid_height;
    logic [RADIUS_W-1:0] radius_sq;
    logic [OCC_TH_W-1:0] occupancy_threshold;
    logic [COV_W-1:0]    coverage_threshold;
    logic [MASK_W-1:0]   pauseable_state_mask;
  } cfg_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [GEOM_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (32'(v) > 32'(MAX_GRID_SIDE)) begin
      r = SIDE_W'(MAX_GRID_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

endpackage

>>> design/circular_region_occupancy_monitor.sv
// top level of the circular region occupancy monitor: config registers and the two halves
// a pause beat passes from the queue through the stage a, stage b and output registers
// throughput: one input beat per cycle while the queue has room; it fills while a pause beat waits on m_tready
// grid cells and unused commands give no output beat
// reset: synchronous, clears the queue, scan position, counts and latches, dock state to 255
// reset also loads the registers with their defaults; no clearing pass is needed
module circular_region_occupancy_monitor import crom_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // cell_value [7:0], dock_state [15:8]
  input  logic [1:0]           s_tuser,   // cmd [1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // pause [0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t    cfg;
  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width           <= GEOM_W'(200);
      cfg.grid_height          <= GEOM_W'(200);
      cfg.radius_sq            <= RADIUS_W'(36);
      cfg.occupancy_threshold  <= OCC_TH_W'(60);
      cfg.coverage_threshold   <= COV_W'(6554);
      cfg.pauseable_state_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  cfg.grid_width           <= cfg_wdata[GEOM_W-1:0];
        REG_GRID_HEIGHT: cfg.grid_height          <= cfg_wdata[GEOM_W-1:0];
        REG_RADIUS_SQ:   cfg.radius_sq            <= cfg_wdata[RADIUS_W-1:0];
        REG_OCC_TH:      cfg.occupancy_threshold  <= cfg_wdata[OCC_TH_W-1:0];
        REG_COV_TH:      cfg.coverage_threshold   <= cfg_wdata[COV_W-1:0];
        REG_PAUSE_MASK:  cfg.pauseable_state_mask <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  crom_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  crom_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> design/crom_front.sv
// front end: accepts beats, classifies the command and queues the work
module crom_front import crom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cell_value [7:0], dock_state [15:8]
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  output logic        q_valid,
  output q_item_t     q_item,
  input  logic        q_pop
);

  q_item_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   fill;
  logic [FIFO_PTR_W:0]   fill_next;
  logic                  keep;
  logic                  push;
  logic                  pop;
  item_kind_t            kind;

  always_comb begin
    keep = 1'b1;
    kind = KIND_CELL;
    unique case (s_tuser)
      CMD_CELL: kind = KIND_CELL;
      CMD_DOCK: kind = KIND_DOCK;
      CMD_TICK: kind = KIND_TICK;
      default:  keep = 1'b0;
    endcase
  end

  assign s_tready = (fill != (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign push     = s_tvalid && s_tready && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (fill != '0);
  assign q_item   = fifo_mem[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 1'b1;
    end else if (!push && pop) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{kind: kind, cell_value: s_tdata[7:0], dock_state: s_tdata[15:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

endmodule

>>> design/crom_back.sv
// back end: scan position, circle test, counting, latching and pause decision
`include "circular_region_occupancy_monitor_assert.svh"

module crom_back import crom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  q_item_t     q_item,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // pause [0]
);

  logic adv;

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [COUNT_W-1:0] checked_count;
  logic [COUNT_W-1:0] occupied_count;
  logic [COUNT_W-1:0] latched_checked;
  logic [COUNT_W-1:0] latched_occupied;
  logic [7:0] current_dock_state;

  // stage a
  logic               a_valid;
  item_kind_t         a_kind;
  logic               a_occ_hit;
  logic [7:0]         a_dock;
  logic               a_frame_end;
  logic [SQ_W-1:0]    a_sq_x;
  logic [SQ_W-1:0]    a_sq_y;

  // stage b
  logic               b_valid;
  logic               b_elig;
  logic [PROD_W-1:0]  b_prod;
  logic [COUNT_W-1:0] b_occ;

  logic               pause;

  logic [SIDE_W-1:0]        w_side;
  logic [SIDE_W-1:0]        h_side;
  logic signed [COORD_W-1:0] dx;
  logic signed [COORD_W-1:0] dy;
  logic [SIDE_W-1:0]        abs_dx;
  logic [SIDE_W-1:0]        abs_dy;
  logic                     col_wrap;
  logic                     row_wrap;
  logic                     cell_fire;

  logic [DIST_W-1:0]        dist_sq;
  logic                     in_circle;
  logic                     a_cell;
  logic [COUNT_W-1:0]       checked_next;
  logic [COUNT_W-1:0]       occupied_next;
  logic [7:0]               eff_state;
  logic                     elig;

  assign adv   = !m_tvalid || m_tready;
  assign q_pop = adv;

  always_comb begin
    w_side   = clamp_side(cfg.grid_width);
    h_side   = clamp_side(cfg.grid_height);
    dx       = $signed({2'b00, column_count}) - $signed({2'b00, w_side[SIDE_W-1:1]});
    dy       = $signed({1'b0, h_side}) - COORD_W'(1) - $signed({2'b00, row_count})
               - $signed({2'b00, h_side[SIDE_W-1:1]});
    abs_dx   = dx[COORD_W-1] ? SIDE_W'(-dx) : SIDE_W'(dx);
    abs_dy   = dy[COORD_W-1] ? SIDE_W'(-dy) : SIDE_W'(dy);
    col_wrap = ({1'b0, column_count} + SIDE_W'(1)) >= w_side;
    row_wrap = ({1'b0, row_count} + SIDE_W'(1)) >= h_side;
    cell_fire = adv && q_valid && (q_item.kind == KIND_CELL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      a_valid      <= 1'b0;
    end else begin
      if (adv) begin
        a_valid <= q_valid;
      end
      if (cell_fire) begin
        if (col_wrap) begin
          column_count <= '0;
          row_count    <= row_wrap ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind      <= q_item.kind;
      a_occ_hit   <= q_item.cell_value > $signed({1'b0, cfg.occupancy_threshold});
      a_dock      <= q_item.dock_state;
      a_frame_end <= col_wrap && row_wrap;
      a_sq_x      <= SQ_W'(abs_dx * abs_dx);
      a_sq_y      <= SQ_W'(abs_dy * abs_dy);
    end
  end

  always_comb begin
    dist_sq   = DIST_W'(a_sq_x) + DIST_W'(a_sq_y);
    in_circle = dist_sq <= DIST_W'(cfg.radius_sq);
    a_cell    = a_valid && (a_kind == KIND_CELL);
    checked_next  = checked_count;
    occupied_next = occupied_count;
    if (a_cell && in_circle) begin
      if (checked_count != COUNT_MAX) begin
        checked_next = checked_count + 1'b1;
      end
      if (a_occ_hit && occupied_count != COUNT_MAX) begin
        occupied_next = occupied_count + 1'b1;
      end
    end
    eff_state = (a_kind == KIND_DOCK) ? a_dock : current_dock_state;
    elig = (eff_state[7:4] == 4'd0) && cfg.pauseable_state_mask[eff_state[3:0]]
           && (latched_checked != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checked_count      <= '0;
      occupied_count     <= '0;
      latched_checked    <= '0;
      latched_occupied   <= '0;
      current_dock_state <= DOCK_STATE_INVALID;
      b_valid            <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid && (a_kind != KIND_CELL);
      if (a_cell && a_frame_end) begin
        latched_checked  <= checked_next;
        latched_occupied <= occupied_next;
        checked_count    <= '0;
        occupied_count   <= '0;
      end else begin
        checked_count  <= checked_next;
        occupied_count <= occupied_next;
      end
      if (a_valid && a_kind == KIND_DOCK) begin
        current_dock_state <= a_dock;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_elig <= elig;
      b_prod <= cfg.coverage_threshold * latched_checked;
      b_occ  <= latched_occupied;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid) begin
      pause <= b_elig && ({b_occ, {COV_W{1'b0}}} > b_prod);
    end
  end

  assign m_tdata = {7'd0, pause};

  `CROM_ASSERT_IMPLY(occ_within_checked, clk, rst, 1'b1,
    occupied_count <= checked_count && latched_occupied <= latched_checked)
  `CROM_ASSERT_NEXT(stall_holds_scan, clk, rst, !adv,
    $stable(column_count) && $stable(row_count) && $stable(checked_count))
  `CROM_ASSERT_NEXT(frame_end_rewinds, clk, rst, cell_fire && col_wrap && row_wrap,
    column_count == '0 && row_count == '0)

endmodule
